// File: rtl/csc_pkg.sv
// ---------------------------------------------------------------------------
// CORDIC sine/cosine package
// Register indexes, fixed field widths and the arctangent table in degrees.
// ---------------------------------------------------------------------------
package csc_pkg;

	localparam int ANGLE_W  = 24;
	localparam int OUT_W    = 18;
	localparam int CNT_W    = 5;
	localparam int MAG_W    = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 17;

	// x and y stay below about 1.65 times the start magnitude plus rounding slack.
	localparam int XY_W = 21;

	localparam logic [CFG_IDX_W-1:0] REG_ITER_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_MAG  = 2'd1;

	localparam logic [CNT_W-1:0] ITER_COUNT_RESET = 5'd7;
	localparam logic [MAG_W-1:0] START_MAG_RESET  = 17'd39803;

	localparam logic signed [XY_W-1:0] OUT_MAX = 21'sd131071;
	localparam logic signed [XY_W-1:0] OUT_MIN = -21'sd131072;

	localparam int TABLE_SIZE = 24;
	localparam int TABLE_FRAC = 30;

	typedef logic [35:0] atan_entry_t;

	// atan(2^-i) in degrees with 30 fractional bits.
	localparam atan_entry_t ATAN_DEG_Q30 [TABLE_SIZE] = '{
		36'd48318382080, 36'd28524006506, 36'd15071301663, 36'd7650428051,
		36'd3840059795,  36'd1921901881,  36'd961185452,   36'd480622056,
		36'd240314695,   36'd120157806,   36'd60078960,    36'd30039487,
		36'd15019745,    36'd7509872,     36'd3754936,     36'd1877468,
		36'd938734,      36'd469367,      36'd234683,      36'd117342,
		36'd58671,       36'd29335,       36'd14668,       36'd7334
	};

	// Table entry rounded to the nearest step at fb fractional bits, halves up.
	function automatic logic [63:0] atan_entry(input int i, input int fb);
		logic [63:0] v;
		int          sh;
		v  = 64'(ATAN_DEG_Q30[i % TABLE_SIZE]);
		sh = TABLE_FRAC - fb;
		if (sh == 0) begin
			return v;
		end
		return (v + (64'd1 << (sh - 1))) >> sh;
	endfunction

endpackage

// File: rtl/cordic_sine_cosine_top.sv
// ---------------------------------------------------------------------------
// CORDIC sine/cosine, rotation mode
// Unrolled pipeline with one shift-add stage per CORDIC iteration.
// ---------------------------------------------------------------------------
// Pipeline: an accepted angle word passes the input register, one stage per
// iteration and one saturating output register, which raises done and holds
// the result word.
// Throughput: one angle word per clock; busy stays low, since each iteration
// has its own adder stage and the receiver cannot stall the result side.
// Reset: arst_n clears all stage valid bits at once and restores the register
// defaults (7 iterations, start magnitude 39803).
module cordic_sine_cosine_top
	import csc_pkg::*;
#(
	parameter int MAX_ITERATIONS = 15,
	parameter int FRACTION_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [ANGLE_W-1:0]   angle_degrees,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data,
	output logic                        done,
	output logic signed [OUT_W-1:0]     sine_value,
	output logic signed [OUT_W-1:0]     cosine_value,
	output logic                        status
);

	// The residual angle must hold the input plus the sum of all table entries,
	// which stays under about 100 degrees at FRACTION_BITS fractional bits.
	localparam int Z_BASE = (FRACTION_BITS + 9 > ANGLE_W) ? FRACTION_BITS + 9 : ANGLE_W;
	localparam int Z_W    = Z_BASE + 1;
	localparam int NS     = MAX_ITERATIONS + 1;

	// Configuration registers. Write them only while the pipeline is empty; the
	// block itself does not enforce this, and every stage reads them directly.
	logic [CNT_W-1:0] iter_count_q;
	logic [MAG_W-1:0] start_mag_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_count_q <= ITER_COUNT_RESET;
			start_mag_q  <= START_MAG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_ITER_COUNT) begin
				iter_count_q <= cfg_data[CNT_W-1:0];
			end
			if (cfg_index == REG_START_MAG) begin
				start_mag_q <= cfg_data[MAG_W-1:0];
			end
		end
	end

	// Every cycle may take a new angle word.
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Stage arrays: entry 0 is the input register, entry k+1 holds the
	// vector after iteration k. The residual angle is kept only for the
	// stages that still have a rotation to steer.
	logic                   vld_s [NS];
	logic signed [XY_W-1:0] x_s   [NS];
	logic signed [XY_W-1:0] y_s   [NS];
	logic signed [Z_W-1:0]  z_s   [MAX_ITERATIONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s[0] <= XY_W'({1'b0, start_mag_q});
			y_s[0] <= '0;
			z_s[0] <= Z_W'(angle_degrees);
		end
	end

	for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_iter
		logic                   active;
		logic                   rot_pos;
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;

		// Stages beyond the configured count pass the vector through unchanged.
		assign active  = (CNT_W'(k) < iter_count_q);
		assign rot_pos = !z_s[k][Z_W-1] && (|z_s[k]);
		assign dx      = y_s[k] >>> k;
		assign dy      = x_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (vld_s[k]) begin
				if (!active) begin
					x_s[k+1] <= x_s[k];
					y_s[k+1] <= y_s[k];
				end else if (rot_pos) begin
					x_s[k+1] <= x_s[k] - dx;
					y_s[k+1] <= y_s[k] + dy;
				end else begin
					x_s[k+1] <= x_s[k] + dx;
					y_s[k+1] <= y_s[k] - dy;
				end
			end
		end

		// The last stage has no later rotation, so it drops the residual angle.
		if (k < MAX_ITERATIONS - 1) begin : g_angle
			localparam logic signed [Z_W-1:0] DA = Z_W'(atan_entry(k, FRACTION_BITS));

			always_ff @(posedge clk) begin
				if (vld_s[k]) begin
					if (!active) begin
						z_s[k+1] <= z_s[k];
					end else if (rot_pos) begin
						z_s[k+1] <= z_s[k] - DA;
					end else begin
						z_s[k+1] <= z_s[k] + DA;
					end
				end
			end
		end
	end

	// Output register: saturate to the 18-bit range, or report an invalid
	// iteration count with zero outputs.
	logic                   bad_count;
	logic signed [XY_W-1:0] x_last;
	logic signed [XY_W-1:0] y_last;
	logic signed [XY_W-1:0] x_sat;
	logic signed [XY_W-1:0] y_sat;

	assign bad_count = (iter_count_q > CNT_W'(MAX_ITERATIONS));
	assign x_last    = x_s[MAX_ITERATIONS];
	assign y_last    = y_s[MAX_ITERATIONS];

	always_comb begin
		priority if (x_last > OUT_MAX) begin
			x_sat = OUT_MAX;
		end else if (x_last < OUT_MIN) begin
			x_sat = OUT_MIN;
		end else begin
			x_sat = x_last;
		end
		priority if (y_last > OUT_MAX) begin
			y_sat = OUT_MAX;
		end else if (y_last < OUT_MIN) begin
			y_sat = OUT_MIN;
		end else begin
			y_sat = y_last;
		end
	end

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[MAX_ITERATIONS];
		end
	end

	logic signed [OUT_W-1:0] sine_q;
	logic signed [OUT_W-1:0] cosine_q;
	logic                    status_q;

	always_ff @(posedge clk) begin
		if (vld_s[MAX_ITERATIONS]) begin
			if (bad_count) begin
				sine_q   <= '0;
				cosine_q <= '0;
				status_q <= 1'b1;
			end else begin
				sine_q   <= y_sat[OUT_W-1:0];
				cosine_q <= x_sat[OUT_W-1:0];
				status_q <= 1'b0;
			end
		end
	end

	assign done         = done_q;
	assign sine_value   = sine_q;
	assign cosine_value = cosine_q;
	assign status       = status_q;

endmodule

// File: tb/sv/cordic_sine_cosine_top_tb.sv
// ---------------------------------------------------------------------------
// CORDIC sine/cosine testbench
// Drives angle words into the rotation-mode CORDIC block under several
// register settings and compares every done strobe against a shift-add
// prediction of the sine, the cosine and the status.
// ---------------------------------------------------------------------------
module cordic_sine_cosine_top_tb
	import csc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ITER  = 15;
	localparam int FRAC_BITS = 16;
	// One input register, one stage per iteration and one output register.
	localparam int LATENCY   = MAX_ITER + 2;

	// One degree at 16 fractional bits.
	localparam int DEG = 1 << FRAC_BITS;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 24'sh7FFFFF;
	localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -24'sh800000;

	// Register indexes that the block decodes as nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

	// Marks in the phase table below for values that are drawn at random.
	localparam int PICK_ANY_VALID = -1;
	localparam int PICK_ANY       = -2;

	typedef struct {
		logic signed [OUT_W-1:0] sine;
		logic signed [OUT_W-1:0] cosine;
		logic                    status;
	} sincos_t;

	// The checker keeps its own copy of the two registers, predicts the
	// result of every accepted angle word and matches results in order.
	class sincos_checker;
		int unsigned  iter_count;
		logic [16:0]  start_mag;
		sincos_t      expected_q[$];
		int           errors;

		function new();
			iter_count = ITER_COUNT_RESET;
			start_mag  = START_MAG_RESET;
			errors     = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_ITER_COUNT: iter_count = data[CNT_W-1:0];
				REG_START_MAG:  start_mag  = data[MAG_W-1:0];
				default: ;
			endcase
		endfunction

		function logic signed [OUT_W-1:0] clamp_out(longint v);
			if (v > 131071) v = 131071;
			if (v < -131072) v = -131072;
			return v[OUT_W-1:0];
		endfunction

		function sincos_t cordic_predict(logic signed [ANGLE_W-1:0] angle);
			sincos_t r;
			longint  x, y, z, dx, dy, step;
			x = longint'(start_mag);
			y = 0;
			z = longint'(angle);
			if (iter_count > MAX_ITER) begin
				r.sine   = '0;
				r.cosine = '0;
				r.status = 1'b1;
				return r;
			end
			for (int i = 0; i < int'(iter_count); i++) begin
				dx   = y >>> i;
				dy   = x >>> i;
				// Table step rounded from 30 to 16 fractional bits, halves up.
				step = (longint'(ATAN_DEG_Q30[i]) +
					(longint'(1) << (TABLE_FRAC - FRAC_BITS - 1))) >>> (TABLE_FRAC - FRAC_BITS);
				if (z > 0) begin
					x = x - dx;
					y = y + dy;
					z = z - step;
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + step;
				end
			end
			r.sine   = clamp_out(y);
			r.cosine = clamp_out(x);
			r.status = 1'b0;
			return r;
		endfunction

		function void note_angle(logic signed [ANGLE_W-1:0] angle);
			expected_q.push_back(cordic_predict(angle));
		endfunction

		function void check_result(logic signed [OUT_W-1:0] sine,
				logic signed [OUT_W-1:0] cosine, logic st);
			sincos_t e;
			if (expected_q.size() == 0) begin
				$error("result with no angle pending: sine %0d cosine %0d status %0d",
					sine, cosine, st);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (sine !== e.sine) begin
				$error("sine_value: expected %0d, actual %0d", e.sine, sine);
				errors++;
			end
			if (cosine !== e.cosine) begin
				$error("cosine_value: expected %0d, actual %0d", e.cosine, cosine);
				errors++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, st);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	// Every input starts at a known value; reset is held from time zero.
	logic                        clk           = 1'b0;
	logic                        arst_n        = 1'b0;
	logic                        start         = 1'b0;
	logic signed [ANGLE_W-1:0]   angle_degrees = '0;
	logic                        cfg_valid     = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index     = '0;
	logic [CFG_DAT_W-1:0]        cfg_data      = '0;
	logic                        busy;
	logic                        cfg_ready;
	logic                        done;
	logic signed [OUT_W-1:0]     sine_value;
	logic signed [OUT_W-1:0]     cosine_value;
	logic                        status;

	sincos_checker sb = new();

	cordic_sine_cosine_top #(
		.MAX_ITERATIONS(MAX_ITER),
		.FRACTION_BITS (FRAC_BITS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.angle_degrees(angle_degrees),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.sine_value   (sine_value),
		.cosine_value (cosine_value),
		.status       (status)
	);

	always #4 clk = ~clk;

	// The result side cannot be held off, so each done strobe is taken at the
	// edge that closes its cycle. Reading right after the edge sees the values
	// from before it, which keeps the sampling free of races.
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(sine_value, cosine_value, status);
		end
	end

	// A register write waits for cfg_ready, then drops valid for one cycle so
	// that a following write never lowers and raises valid in one time step.
	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// An angle word is taken at the first edge with start high and busy low.
	// The prediction is made right there, with the registers as they stand.
	task automatic send_angle(input logic signed [ANGLE_W-1:0] a);
		start         <= 1'b1;
		angle_degrees <= a;
		do @(posedge clk); while (busy);
		sb.note_angle(a);
	endtask

	// While the sender idles the angle bus carries junk, which must be ignored.
	task automatic pause_sender(input int cycles);
		start         <= 1'b0;
		angle_degrees <= ANGLE_W'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// Stop sending, wait for every pending result, then let the pipeline
	// run empty before anything touches the registers.
	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Most angles lie in the range where the iteration converges. The rest
	// sit near zero, where the direction choice flips on the sign of the
	// residual, or from 90 degrees out to the field extremes, or anywhere in the field.
	function automatic logic signed [ANGLE_W-1:0] random_angle();
		int unsigned pick;
		int          a;
		pick = $urandom_range(99);
		if (pick < 65) begin
			a = int'($urandom_range(180 * DEG)) - 90 * DEG;
		end else if (pick < 75) begin
			a = int'($urandom_range(32)) - 16;
		end else if (pick < 85) begin
			a = int'($urandom_range(int'(ANGLE_MAX), 90 * DEG));
			if ($urandom_range(1) == 1) begin
				a = -a - 1;
			end
		end else begin
			a = int'($urandom);
		end
		return a[ANGLE_W-1:0];
	endfunction

	// Each cycle idles with a chance of idle_pct percent, so about that share
	// of the cycles in a phase carry no angle word.
	task automatic run_phase(input int n_items, input int idle_pct);
		for (int i = 0; i < n_items; i++) begin
			while (int'($urandom_range(99)) < idle_pct) begin
				pause_sender(1);
			end
			send_angle(random_angle());
		end
		drain();
	endtask

	// The upper bits of the count register's data are junk that the block
	// must drop, so every bit of the data port gets toggled.
	task automatic set_iterations(input int unsigned n);
		write_cfg(REG_ITER_COUNT, (CFG_DAT_W'($urandom) & 17'h1FFE0) | CFG_DAT_W'(n));
	endtask

	// Each random phase sets both registers first. Settings include the
	// saturating maximum magnitude, a zero magnitude, zero iterations and
	// counts beyond the limit, which give the error status.
	int phase_iter[9] = '{15, 0, 16, 31, 1, PICK_ANY_VALID, 15, PICK_ANY, 10};
	int phase_mag[9]  = '{39803, 131071, PICK_ANY, 0, 131071, PICK_ANY, 131071, 39803,
		PICK_ANY};

	initial begin
		int n;
		int m;
		int idle_pct;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset settings: zero, the smallest steps,
		// right angles, the field extremes and the edge of convergence.
		send_angle('0);
		send_angle(24'sd1);
		send_angle(-24'sd1);
		send_angle(ANGLE_W'(90 * DEG));
		send_angle(ANGLE_W'(-90 * DEG));
		send_angle(ANGLE_W'(45 * DEG));
		send_angle(ANGLE_W'(-45 * DEG));
		send_angle(ANGLE_W'(30 * DEG));
		send_angle(ANGLE_W'(60 * DEG));
		send_angle(ANGLE_MAX);
		send_angle(ANGLE_MIN);
		send_angle(ANGLE_W'(6547046));
		send_angle(ANGLE_W'(-6547046));
		drain();

		// With no iterations the cosine is the start magnitude, sine zero.
		set_iterations(0);
		send_angle(ANGLE_W'(30 * DEG));
		send_angle(ANGLE_W'(-60 * DEG));
		drain();

		// One iteration past the limit gives the error status.
		set_iterations(MAX_ITER + 1);
		send_angle(ANGLE_W'(45 * DEG));
		drain();

		// The full magnitude drives both outputs into saturation.
		set_iterations(MAX_ITER);
		write_cfg(REG_START_MAG, 17'h1FFFF);
		send_angle('0);
		send_angle(ANGLE_W'(90 * DEG));
		send_angle(ANGLE_W'(-45 * DEG));
		send_angle(ANGLE_MAX);
		drain();

		// Writes to unused indexes must change nothing.
		write_cfg(REG_UNUSED_2, CFG_DAT_W'($urandom));
		write_cfg(REG_UNUSED_3, CFG_DAT_W'($urandom));
		send_angle(ANGLE_W'(45 * DEG));
		drain();

		// Random phases: the sender idles rarely at first, then heavily, and
		// in the last third it never idles.
		for (int p = 0; p < 9; p++) begin
			n = phase_iter[p];
			if (n == PICK_ANY_VALID) begin
				n = $urandom_range(MAX_ITER);
			end else if (n == PICK_ANY) begin
				n = $urandom_range(31);
			end
			m = phase_mag[p];
			if (m == PICK_ANY) begin
				m = $urandom_range(131071);
			end
			set_iterations(n);
			write_cfg(REG_START_MAG, CFG_DAT_W'(m));
			if ($urandom_range(1) == 1) begin
				write_cfg(REG_UNUSED_2, CFG_DAT_W'($urandom));
			end else begin
				write_cfg(REG_UNUSED_3, CFG_DAT_W'($urandom));
			end
			idle_pct = (p < 3) ? 8 : ((p < 6) ? 54 : 0);
			run_phase(150, idle_pct);
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("cordic_sine_cosine_top: match");
		end else begin
			$display("cordic_sine_cosine_top: mismatch");
		end
		$finish;
	end

	// Guard against a hang, far above the length of a correct run.
	initial begin
		#2_000_000;
		$display("cordic_sine_cosine_top: mismatch");
		$finish;
	end

endmodule
